// ===== sv/ple_pkg.sv =====
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } ple_mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } ple_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_INS,
        S_DOWN,
        S_DONE
    } ple_state_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value_in;
    } ple_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [1:0]               status;
        logic [CNT_W-1:0]         entry_count;
        logic                     list_empty;
    } ple_rsp_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ple_mem_req_t;

endpackage

// ===== sv/ple_store.sv =====
module ple_store
    import ple_pkg::*;
(
    input  logic               clk,
    input  ple_mem_req_t       mem_req,
    output logic [DATA_W-1:0]  rdata
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/positional_list_engine_unit.sv =====
// A clear or a rejected request goes straight to its response and an insert at the end of
// the list writes the value at once; a read fetches the entry at p; an insert at p below count
// moves the entries from count - 1 down to p up one slot and then writes the value, and a remove
// reads p to the end, returns the entry at p and moves the rest down; entries move one per cycle.
// One request at a time; the next is accepted once its response enters a free output register.
// Reset clears the entry count and the handshake state; the entry memory is not cleared.
module positional_list_engine_unit
    import ple_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ple_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ple_rsp_t rsp
);

    ple_state_t        state_reg, state_next;
    ple_mode_t         mode_reg, mode_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [IDX_W-1:0]  stop_reg, stop_next;
    logic [IDX_W-1:0]  wa_reg, wa_next;
    logic              issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic              pend_first_reg, pend_first_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    ple_status_t       res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    ple_rsp_t          out_data_reg, out_data_next;

    ple_mem_req_t      mem_req;
    logic [DATA_W-1:0] rdata;

    ple_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        cursor_reg     <= cursor_next;
        stop_reg       <= stop_next;
        wa_reg         <= wa_next;
        pend_first_reg <= pend_first_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    // Each memory read returns in the next cycle and is written back one slot away, so a
    // shift never writes an entry that is still waiting to be read.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        cursor_next     = cursor_reg;
        stop_next       = stop_reg;
        wa_next         = wa_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_first_next = pend_first_reg;
        count_next      = count_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_data_next   = out_data_reg;
        req_ready       = (state_reg == S_IDLE);

        mem_req.we    = 1'b0;
        mem_req.waddr = wa_reg;
        mem_req.wdata = rdata;
        mem_req.re    = 1'b0;
        mem_req.raddr = cursor_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next       = ple_mode_t'(req.mode);
                    pos_next        = req.position[IDX_W-1:0];
                    val_next        = req.value_in;
                    res_value_next  = '0;
                    res_status_next = ST_DONE;
                    issue_next      = 1'b0;
                    pend_next       = 1'b0;
                    case (ple_mode_t'(req.mode))
                        MODE_INSERT:
                        begin
                            if (req.position > count_reg)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else if (count_reg >= CAP_COUNT)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (req.position == count_reg)
                            begin
                                state_next = S_INS;
                            end
                            else
                            begin
                                cursor_next = IDX_W'(count_reg - CNT_W'(1));
                                issue_next  = 1'b1;
                                state_next  = S_UP;
                            end
                        end
                        MODE_REMOVE, MODE_READ:
                        begin
                            if (req.position >= count_reg)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                cursor_next = req.position[IDX_W-1:0];
                                if (ple_mode_t'(req.mode) == MODE_REMOVE)
                                begin
                                    stop_next = IDX_W'(count_reg - CNT_W'(1));
                                end
                                else
                                begin
                                    stop_next = req.position[IDX_W-1:0];
                                end
                                issue_next = 1'b1;
                                state_next = S_DOWN;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                if (pend_reg)
                begin
                    mem_req.we = 1'b1;
                end
                if (issue_reg)
                begin
                    mem_req.re = 1'b1;
                    pend_next  = 1'b1;
                    wa_next    = cursor_reg + IDX_W'(1);
                    if (cursor_reg == pos_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cursor_next = cursor_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_DONE;
            end
            S_DOWN:
            begin
                if (pend_reg)
                begin
                    if (pend_first_reg)
                    begin
                        res_value_next = rdata;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                    end
                end
                if (issue_reg)
                begin
                    mem_req.re      = 1'b1;
                    pend_next       = 1'b1;
                    pend_first_next = (cursor_reg == pos_reg);
                    wa_next         = cursor_reg - IDX_W'(1);
                    if (cursor_reg == stop_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                    if (mode_reg == MODE_REMOVE)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.value_out   = res_value_reg;
                    out_data_next.status      = res_status_reg;
                    out_data_next.entry_count = count_reg;
                    out_data_next.list_empty  = (count_reg == '0);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count exceeds capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("memory read and write hit the same entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || rsp_ready)) |=> rsp_valid)
        else $error("finished request produced no response");

endmodule

// ===== tb/tb_positional_list_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;
    import ple_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    ple_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    ple_rsp_t rsp;

    // Shadow copy of the list, updated when a request is accepted.
    logic [DATA_W-1:0] list_model [CAPACITY];
    logic [CNT_W-1:0]  model_count;
    ple_rsp_t          predicted_rsp [$];

    int errors;
    bit steady_flow;
    int hold_off_cycles;

    positional_list_engine_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic ple_rsp_t list_apply(ple_req_t r);
        ple_rsp_t o;
        int       i;
        o.value_out = '0;
        o.status    = ST_DONE;
        case (ple_mode_t'(r.mode))
            MODE_INSERT:
            begin
                if (r.position > model_count)
                    o.status = ST_RANGE;
                else if (model_count >= CAP_COUNT)
                    o.status = ST_FULL;
                else
                begin
                    for (i = int'(model_count); i > int'(r.position); i--)
                        list_model[i] = list_model[i-1];
                    list_model[r.position] = r.value_in;
                    model_count++;
                end
            end
            MODE_REMOVE:
            begin
                if (r.position >= model_count)
                    o.status = ST_RANGE;
                else
                begin
                    o.value_out = list_model[r.position];
                    for (i = int'(r.position); i + 1 < int'(model_count); i++)
                        list_model[i] = list_model[i+1];
                    model_count--;
                end
            end
            MODE_READ:
            begin
                if (r.position >= model_count)
                    o.status = ST_RANGE;
                else
                    o.value_out = list_model[r.position];
            end
            default:
                model_count = '0;
        endcase
        o.entry_count = model_count;
        o.list_empty  = (model_count == 0);
        return o;
    endfunction

    function automatic int draw_wait();
        if (steady_flow)
            return 0;
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-range positions; the rest spread over the whole 5-bit field.
    function automatic logic [POS_W-1:0] pick_position(bit for_insert);
        int top;
        top = int'(model_count) - (for_insert ? 0 : 1);
        if (top < 0 || $urandom_range(0, 99) < 12)
            return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(0, top));
    endfunction

    task automatic send_request(ple_mode_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.mode     = op;
        req.position = pos;
        req.value_in = val;
        req_valid    = 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        predicted_rsp.push_back(list_apply(req));
    endtask

    task automatic test_directed_edges();
        send_request(MODE_READ,   5'd0,  $urandom);
        send_request(MODE_REMOVE, 5'd31, $urandom);
        send_request(MODE_INSERT, 5'd1,  $urandom);
        send_request(MODE_INSERT, 5'd0,  32'h8000_0000);
        send_request(MODE_INSERT, 5'd1,  32'h7fff_ffff);
        send_request(MODE_INSERT, 5'd0,  32'hffff_ffff);
        send_request(MODE_INSERT, 5'd1,  32'h0000_0000);
        for (int p = 0; p < 5; p++)
            send_request(MODE_READ, POS_W'(p), $urandom);
        send_request(MODE_INSERT, 5'd31, $urandom);
        send_request(MODE_REMOVE, 5'd2,  $urandom);
        send_request(MODE_REMOVE, 5'd0,  $urandom);
        send_request(MODE_REMOVE, 5'd1,  $urandom);
        send_request(MODE_CLEAR,  5'd31, $urandom);
        send_request(MODE_READ,   5'd0,  $urandom);
        send_request(MODE_REMOVE, 5'd0,  $urandom);
        send_request(MODE_CLEAR,  5'd0,  $urandom);
    endtask

    task automatic test_fill_to_capacity();
        send_request(MODE_CLEAR, 5'd0, $urandom);
        while (model_count < CAP_COUNT)
            send_request(MODE_INSERT, POS_W'($urandom_range(0, model_count)), pick_value());
        // A full list rejects an insert as full only after its position has passed the range check.
        send_request(MODE_INSERT, 5'd16, $urandom);
        send_request(MODE_INSERT, 5'd0,  $urandom);
        send_request(MODE_INSERT, 5'd17, $urandom);
        send_request(MODE_INSERT, 5'd31, $urandom);
        send_request(MODE_READ,   5'd15, $urandom);
        send_request(MODE_READ,   5'd16, $urandom);
        send_request(MODE_REMOVE, 5'd15, $urandom);
        send_request(MODE_INSERT, 5'd15, pick_value());
        while (model_count > 0)
            send_request(MODE_REMOVE, POS_W'($urandom_range(0, model_count - 1)), $urandom);
    endtask

    task automatic test_random_mix(int n, int insert_pct, int remove_pct);
        int roll;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                send_request(MODE_INSERT, pick_position(1'b1), pick_value());
            else if (roll < insert_pct + remove_pct)
                send_request(MODE_REMOVE, pick_position(1'b0), $urandom);
            else if (roll < 97)
                send_request(MODE_READ, pick_position(1'b0), $urandom);
            else
                send_request(MODE_CLEAR, POS_W'($urandom_range(0, 31)), $urandom);
        end
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        test_random_mix(40, 45, 30);
        steady_flow = 1'b0;
    endtask

    task automatic test_output_stall();
        // The response side stops for a long stretch while requests keep coming.
        hold_off_cycles = 300;
        steady_flow     = 1'b1;
        test_random_mix(25, 45, 30);
        steady_flow     = 1'b0;
    endtask

    initial
    begin : response_checker
        int       stall;
        ple_rsp_t want;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                rsp_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready = 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
            if (predicted_rsp.size() == 0)
            begin
                $display("%0t: response with no request outstanding: value %0d status %0d count %0d",
                         $realtime, rsp.value_out, rsp.status, rsp.entry_count);
                errors++;
            end
            else
            begin
                want = predicted_rsp.pop_front();
                if (rsp.value_out !== want.value_out)
                begin
                    $display("%0t: value_out expected %0d got %0d",
                             $realtime, want.value_out, rsp.value_out);
                    errors++;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $realtime, want.status, rsp.status);
                    errors++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d got %0d",
                             $realtime, want.entry_count, rsp.entry_count);
                    errors++;
                end
                if (rsp.list_empty !== want.list_empty)
                begin
                    $display("%0t: list_empty expected %0b got %0b",
                             $realtime, want.list_empty, rsp.list_empty);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors          = 0;
        steady_flow     = 1'b0;
        hold_off_cycles = 0;
        model_count     = '0;
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_fill_to_capacity();
        test_random_mix(100, 55, 20);
        test_back_to_back();
        test_random_mix(100, 35, 35);
        test_output_stall();
        test_random_mix(80, 20, 55);
        test_random_mix(80, 50, 25);

        @(negedge clk);
        req_valid = 1'b0;
        while (predicted_rsp.size() != 0)
            @(posedge clk);
        // A stray extra response would show up within one full request time.
        repeat (CAPACITY + 8) @(posedge clk);
        if (errors == 0)
            $display("positional_list_engine_unit test passed");
        else
            $display("positional_list_engine_unit test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("positional_list_engine_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ple_pkg.sv
sv/ple_store.sv
sv/positional_list_engine_unit.sv
tb/tb_positional_list_engine_unit.sv
